// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdo_pkg.sv =====
// Package for the rate disturbance observer: widths, microcode types and program.
`timescale 1ns / 1ps

package rdo_pkg;

    localparam int AXES        = 3;
    localparam int AXW         = 2;
    localparam int VW          = 32;          // Q16.16 value width
    localparam int GW          = 24;          // gain width, Q8.16
    localparam int DTW         = 24;          // step time width, Q0.24
    localparam int EW          = 32;          // |meas - rate| fits 32 bits
    localparam int GEW         = 56;          // |g*e|
    localparam int GDTW        = 48;          // g*dt
    localparam int SW          = 59;          // signed rate sum
    localparam int SMW         = 58;          // |rate sum|
    localparam int MAW         = 32;          // multiplier A port
    localparam int MBW         = 24;          // multiplier B port
    localparam int PW          = MAW + MBW;   // product width
    localparam int ACCW        = 105;
    localparam int RATE_SH     = 40;
    localparam int DIST_SH     = 56;
    localparam int RINC_W      = 42;
    localparam int DINC_W      = 49;
    localparam int UPW         = DINC_W + 2;  // estimate update adder width
    localparam int PCW         = 4;
    localparam int IN_TDATA_W  = 6 * VW + DTW;
    localparam int OUT_TDATA_W = 6 * VW;

    typedef enum logic [1:0] {
        REG_GAIN_X = 2'd0,
        REG_GAIN_Y = 2'd1,
        REG_GAIN_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ERR,     // e = meas - rate estimate, as magnitude and sign
        OP_GDT,     // latch g*dt
        OP_GE,      // latch |g*e| and signed g*e
        OP_SUM,     // s = (u + d) << 16 + 2*g*e
        OP_ABS,     // |s| and sign
        OP_RATE,    // round, apply and saturate rate increment
        OP_DIST,    // round, apply and saturate disturbance increment
        OP_CLR      // zero all estimates
    } op_t;

    typedef enum logic [2:0] {
        A_E,
        A_S_LO,
        A_S_HI,
        A_GE_LO,
        A_GE_HI,
        A_G
    } a_sel_t;

    typedef enum logic [1:0] {
        B_G,
        B_DT,
        B_GDT_LO,
        B_GDT_HI
    } b_sel_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_24,
        SH_32,
        SH_56
    } sh_t;

    typedef enum logic [1:0] {
        INIT_ACC,     // accumulate onto acc
        INIT_ZERO,    // start from zero
        INIT_HALF40,  // start from the rounding half for the rate shift
        INIT_HALF56   // start from the rounding half for the disturbance shift
    } init_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,     // next axis, or on to the result step
        SEQ_DONE      // hand result to the output register, then idle
    } seq_t;

    typedef struct packed {
        op_t    op;
        logic   mul;
        a_sel_t a;
        b_sel_t b;
        sh_t    sh;
        init_t  init;
        seq_t   seq;
    } uword_t;

    localparam logic [PCW-1:0] ADDR_AXIS = 4'd0;
    localparam logic [PCW-1:0] ADDR_CLR  = 4'd12;
    localparam logic [PCW-1:0] ADDR_DONE = 4'd13;

    function automatic uword_t mk(input op_t op, input logic mul, input a_sel_t a,
                                  input b_sel_t b, input sh_t sh, input init_t init,
                                  input seq_t seq);
        uword_t w;
        w = '{op: op, mul: mul, a: a, b: b, sh: sh, init: init, seq: seq};
        return w;
    endfunction

    // Control store: steps 0..11 run one axis, 12 clears, 13 delivers.
    function automatic uword_t ucode(input logic [PCW-1:0] pc);
        uword_t w;
        unique case (pc)
            4'd0:  w = mk(OP_ERR,  1'b1, A_G,     B_DT,     SH_0,  INIT_ZERO,   SEQ_NEXT);
            4'd1:  w = mk(OP_GDT,  1'b1, A_E,     B_G,      SH_0,  INIT_ZERO,   SEQ_NEXT);
            4'd2:  w = mk(OP_GE,   1'b0, A_E,     B_G,      SH_0,  INIT_ACC,    SEQ_NEXT);
            4'd3:  w = mk(OP_SUM,  1'b0, A_E,     B_G,      SH_0,  INIT_ACC,    SEQ_NEXT);
            4'd4:  w = mk(OP_ABS,  1'b0, A_E,     B_G,      SH_0,  INIT_ACC,    SEQ_NEXT);
            4'd5:  w = mk(OP_NOP,  1'b1, A_S_LO,  B_DT,     SH_0,  INIT_HALF40, SEQ_NEXT);
            4'd6:  w = mk(OP_NOP,  1'b1, A_S_HI,  B_DT,     SH_32, INIT_ACC,    SEQ_NEXT);
            4'd7:  w = mk(OP_RATE, 1'b1, A_GE_LO, B_GDT_LO, SH_0,  INIT_HALF56, SEQ_NEXT);
            4'd8:  w = mk(OP_NOP,  1'b1, A_GE_LO, B_GDT_HI, SH_24, INIT_ACC,    SEQ_NEXT);
            4'd9:  w = mk(OP_NOP,  1'b1, A_GE_HI, B_GDT_LO, SH_32, INIT_ACC,    SEQ_NEXT);
            4'd10: w = mk(OP_NOP,  1'b1, A_GE_HI, B_GDT_HI, SH_56, INIT_ACC,    SEQ_NEXT);
            4'd11: w = mk(OP_DIST, 1'b0, A_E,     B_G,      SH_0,  INIT_ACC,    SEQ_LOOP);
            4'd12: w = mk(OP_CLR,  1'b0, A_E,     B_G,      SH_0,  INIT_ACC,    SEQ_NEXT);
            default: w = mk(OP_NOP, 1'b0, A_E,    B_G,      SH_0,  INIT_ACC,    SEQ_DONE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rate_disturbance_observer.sv =====
// Three-axis extended state observer run by a microcoded multiply-accumulate datapath.
`timescale 1ns / 1ps
// An update result, or a clear result, is loaded into the m_axis register once its
//   program has run and no older result is unclaimed; one item is in work at a time.
// Updates are paced by the single shared 32x24 multiplier: eight partial products
//   per axis, twelve control steps per axis.
// Reset (rst_n low, asynchronous): estimates and gains zero, sequencer idle, no result.

module rate_disturbance_observer
    import rdo_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: meas_rate_x, meas_rate_y, meas_rate_z, drive_x, drive_y, drive_z, step_time
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd
    input  logic                   s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: est_rate_x, est_rate_y, est_rate_z, est_dist_x, est_dist_y, est_dist_z
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [GW-1:0]          cfg_data
);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [PCW-1:0] pc_reg, pc_next;
    logic [AXW-1:0] axis_reg, axis_next;
    logic           busy_reg, busy_next;
    logic           m_valid_reg, m_valid_next;
    logic           out_load;
    logic           in_accept;
    logic           out_free;
    uword_t         uw;

    // Architectural state and configuration
    logic [GW-1:0]  gain_reg      [AXES];
    logic [VW-1:0]  rate_est_reg  [AXES];
    logic [VW-1:0]  dist_est_reg  [AXES];

    // Latched sample (payload, no reset)
    logic [VW-1:0]  meas_reg      [AXES];
    logic [VW-1:0]  drive_reg     [AXES];
    logic [DTW-1:0] dt_reg;

    // Datapath working registers (payload, no reset)
    logic [EW-1:0]   e_mag_reg;
    logic            e_neg_reg;
    logic [GDTW-1:0] gdt_reg;
    logic [GEW-1:0]  ge_mag_reg;
    logic [GEW:0]    ge_s_reg;      // signed g*e, two's complement
    logic [SW-1:0]   s_reg;         // signed rate sum
    logic [SMW-1:0]  s_mag_reg;
    logic            s_neg_reg;
    logic [ACCW-1:0] acc_reg, acc_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // Per-axis operands of the current step
    logic [GW-1:0]  g_cur;
    logic [VW-1:0]  r_cur, d_cur, meas_cur, u_cur;

    // Multiplier and accumulator
    logic [MAW-1:0]  mul_a;
    logic [MBW-1:0]  mul_b;
    logic [PW-1:0]   prod;
    logic [ACCW-1:0] addend, acc_base;

    // Error, sum and estimate update logic
    logic [VW:0]     diff_p, diff_n;
    logic [SW-1:0]   ud_ext, s_calc, s_negated;
    logic [GEW:0]    ge_pos;
    logic [DINC_W-1:0] inc_mag;
    logic            inc_neg;
    logic [VW-1:0]   old_val;
    logic [UPW-1:0]  upd_sum;
    logic [VW-1:0]   upd_val;

    function automatic logic [VW-1:0] sat32(input logic [UPW-1:0] x);
        logic hi_ovf;
        logic lo_ovf;
        logic [VW-1:0] y;
        hi_ovf = !x[UPW-1] && (|x[UPW-2:VW-1]);
        lo_ovf = x[UPW-1] && !(&x[UPW-2:VW-1]);
        priority if (hi_ovf) y = {1'b0, {(VW-1){1'b1}}};
        else if (lo_ovf)     y = {1'b1, {(VW-1){1'b0}}};
        else                 y = x[VW-1:0];
        return y;
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign s_axis_tready = !busy_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;   // gains written only while idle (user; not enforced)

    assign uw = ucode(pc_reg);

    assign g_cur    = gain_reg[axis_reg];
    assign r_cur    = rate_est_reg[axis_reg];
    assign d_cur    = dist_est_reg[axis_reg];
    assign meas_cur = meas_reg[axis_reg];
    assign u_cur    = drive_reg[axis_reg];

    // ------------------------------------------------------------------
    // Step counter, axis loop and result handoff
    // ------------------------------------------------------------------
    always_comb
    begin
        pc_next      = pc_reg;
        axis_next    = axis_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        out_load     = 1'b0;
        if (in_accept)
        begin
            // a clear command skips the axis program
            pc_next   = s_axis_tuser ? ADDR_CLR : ADDR_AXIS;
            axis_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (uw.seq)
                SEQ_NEXT: pc_next = PCW'(pc_reg + 1'b1);
                SEQ_LOOP:
                begin
                    if (axis_reg == AXW'(AXES - 1))
                    begin
                        pc_next = ADDR_DONE;
                    end
                    else
                    begin
                        axis_next = AXW'(axis_reg + 1'b1);
                        pc_next   = ADDR_AXIS;
                    end
                end
                SEQ_DONE:
                begin
                    // wait here while an older result is still unclaimed
                    if (out_free)
                    begin
                        out_load     = 1'b1;
                        busy_next    = 1'b0;
                        m_valid_next = 1'b1;
                    end
                end
                default: pc_next = ADDR_DONE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared 32x24 multiplier feeding a shift-and-add accumulator.
    // Wide operands are taken apart into limbs; the control word picks the
    // limbs, the weight of the partial product and the start value. Starting
    // from a half LSB of the final shift makes the later cut a rounding.
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (uw.a)
            A_E:     mul_a = e_mag_reg;
            A_S_LO:  mul_a = s_mag_reg[MAW-1:0];
            A_S_HI:  mul_a = MAW'(s_mag_reg[SMW-1:MAW]);
            A_GE_LO: mul_a = ge_mag_reg[MAW-1:0];
            A_GE_HI: mul_a = MAW'(ge_mag_reg[GEW-1:MAW]);
            A_G:     mul_a = MAW'(g_cur);
            default: mul_a = '0;
        endcase
        unique case (uw.b)
            B_G:      mul_b = g_cur;
            B_DT:     mul_b = dt_reg;
            B_GDT_LO: mul_b = gdt_reg[MBW-1:0];
            B_GDT_HI: mul_b = gdt_reg[GDTW-1:MBW];
            default:  mul_b = '0;
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    always_comb
    begin
        unique case (uw.sh)
            SH_0:    addend = ACCW'(prod);
            SH_24:   addend = ACCW'(prod) << MBW;
            SH_32:   addend = ACCW'(prod) << MAW;
            SH_56:   addend = ACCW'(prod) << (MAW + MBW);
            default: addend = '0;
        endcase
        unique case (uw.init)
            INIT_ACC:    acc_base = acc_reg;
            INIT_ZERO:   acc_base = '0;
            INIT_HALF40: acc_base = ACCW'(1) << (RATE_SH - 1);
            INIT_HALF56: acc_base = ACCW'(1) << (DIST_SH - 1);
            default:     acc_base = '0;
        endcase
        acc_next = acc_base + addend;
    end

    // ------------------------------------------------------------------
    // Error, rate sum and estimate update
    // ------------------------------------------------------------------
    // both differences side by side; the sign picks the magnitude
    assign diff_p = {meas_cur[VW-1], meas_cur} - {r_cur[VW-1], r_cur};
    assign diff_n = {r_cur[VW-1], r_cur} - {meas_cur[VW-1], meas_cur};

    assign ge_pos = {1'b0, acc_reg[GEW-1:0]};

    // s = (u + d) * 2^16 + 2*g*e, exact
    assign ud_ext    = SW'($signed(u_cur)) + SW'($signed(d_cur));
    assign s_calc    = (ud_ext << 16) + {ge_s_reg[GEW], ge_s_reg, 1'b0};
    assign s_negated = SW'(0) - s_reg;

    // rounded increment magnitude comes straight out of the accumulator
    always_comb
    begin
        if (uw.op == OP_DIST)
        begin
            inc_mag = acc_reg[DIST_SH +: DINC_W];
            inc_neg = e_neg_reg;
            old_val = d_cur;
        end
        else
        begin
            inc_mag = DINC_W'(acc_reg[RATE_SH +: RINC_W]);
            inc_neg = s_neg_reg;
            old_val = r_cur;
        end
    end

    // old + (neg ? -q : q) as one add with carry in
    assign upd_sum = UPW'($signed(old_val))
                   + (inc_neg ? ~{2'b00, inc_mag} : {2'b00, inc_mag})
                   + UPW'(inc_neg);
    assign upd_val = sat32(upd_sum);

    // ------------------------------------------------------------------
    // Control state, gains and estimates
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= ADDR_DONE;
            axis_reg    <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                gain_reg[i]     <= '0;
                rate_est_reg[i] <= '0;
                dist_est_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg      <= pc_next;
            axis_reg    <= axis_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                // index beyond gain_z is dropped
                case (cfg_index)
                    REG_GAIN_X: gain_reg[0] <= cfg_data;
                    REG_GAIN_Y: gain_reg[1] <= cfg_data;
                    REG_GAIN_Z: gain_reg[2] <= cfg_data;
                    default: ;
                endcase
            end

            if (busy_reg)
            begin
                unique case (uw.op)
                    OP_RATE: rate_est_reg[axis_reg] <= upd_val;
                    OP_DIST: dist_est_reg[axis_reg] <= upd_val;
                    OP_CLR:
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            rate_est_reg[i] <= '0;
                            dist_est_reg[i] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload: sample latch, datapath registers, result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                meas_reg[i]  <= s_axis_tdata[i*VW +: VW];
                drive_reg[i] <= s_axis_tdata[(AXES + i)*VW +: VW];
            end
            dt_reg <= s_axis_tdata[2*AXES*VW +: DTW];
        end

        if (busy_reg)
        begin
            if (uw.mul)
            begin
                acc_reg <= acc_next;
            end
            unique case (uw.op)
                OP_ERR:
                begin
                    e_neg_reg <= diff_p[VW];
                    e_mag_reg <= diff_p[VW] ? diff_n[EW-1:0] : diff_p[EW-1:0];
                end
                OP_GDT: gdt_reg <= acc_reg[GDTW-1:0];
                OP_GE:
                begin
                    ge_mag_reg <= acc_reg[GEW-1:0];
                    ge_s_reg   <= e_neg_reg ? (GEW+1)'(0) - ge_pos : ge_pos;
                end
                OP_SUM: s_reg <= s_calc;
                OP_ABS:
                begin
                    s_neg_reg <= s_reg[SW-1];
                    s_mag_reg <= s_reg[SW-1] ? s_negated[SMW-1:0] : s_reg[SMW-1:0];
                end
                default: ;
            endcase
        end

        if (out_load)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                out_data_reg[i*VW +: VW]          <= rate_est_reg[i];
                out_data_reg[(AXES + i)*VW +: VW] <= dist_est_reg[i];
            end
        end
    end

endmodule

// ===== rtl/rdo_checker.sv =====
// Port-level checker for the rate disturbance observer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdo_checker
    import rdo_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // one item in work at a time
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted while an item is in work")

    // the block only frees up by handing over a result
    `ASSERT_SAME(a_result_on_free, clk, rst_n,
        $rose(s_axis_tready), m_axis_tvalid,
        "sequencer went idle without a result")

    `ASSERT_NEXT(a_out_valid_holds, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "result dropped while stalled")

    `ASSERT_NEXT(a_out_data_holds, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
        "result changed while stalled")

endmodule

bind rate_disturbance_observer rdo_checker u_rdo_checker (.*);

// ===== sim/tb_rate_disturbance_observer.sv =====
// Self-checking testbench for the three-axis rate disturbance observer.
`timescale 1ns / 1ps

module tb_rate_disturbance_observer;
    import rdo_pkg::*;

    // Q16.16, Q8.16 and Q0.24 corner values used by the directed table
    localparam logic [VW-1:0]  Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [VW-1:0]  Q_MIN  = 32'h8000_0000;
    localparam logic [VW-1:0]  Q_NEG1 = 32'hFFFF_FFFF;
    localparam logic [VW-1:0]  Q_ONE  = 32'h0001_0000;
    localparam logic [DTW-1:0] DT_MAX = 24'hFF_FFFF;
    localparam logic [GW-1:0]  G_MAX  = 24'hFF_FFFF;
    localparam logic [GW-1:0]  G_ONE  = 24'h01_0000;
    // index past gain_z; the block must drop writes to it
    localparam logic [1:0]     REG_UNUSED = 2'd3;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int IDLE_PCT        = 34;
    localparam int SETTLE_CYCLES   = 40;

    // one input transaction: meas_rate x/y/z lowest, then drive x/y/z, then step_time
    typedef struct packed {
        logic [DTW-1:0]     step_time;
        logic [2:0][VW-1:0] drive;
        logic [2:0][VW-1:0] meas;
    } sample_t;

    // one result transaction: est_rate x/y/z lowest, then est_dist x/y/z
    typedef struct packed {
        logic [2:0][VW-1:0] disturb;
        logic [2:0][VW-1:0] rate;
    } estimates_t;

    // directed rows either send an item or reload the gains
    typedef enum logic {ROW_ITEM, ROW_GAINS} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               cmd;
        sample_t            smp;
        logic               typed;     // expected result written into the row
        estimates_t         want;
        logic [2:0][GW-1:0] gains;
    } stim_row_t;

    typedef struct packed {
        logic       typed;
        estimates_t want;
    } row_expect_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [GW-1:0]          cfg_data;

    // observer state mirrored by the testbench
    logic [GW-1:0]        gain_model [3];
    logic signed [VW-1:0] rate_model [3];
    logic signed [VW-1:0] dist_model [3];

    estimates_t  pending_estimates [$];   // results still owed by the block
    row_expect_t row_expectations [$];    // per sent item: typed answer or not
    stim_row_t   directed_rows [$];

    logic        steady;                  // suppresses idling on both sides
    int          mismatches;
    int          results_checked;
    int          updates_seen;
    int          clears_seen;
    int          gain_settings;

    row_expect_t row_ref;
    estimates_t  predicted;
    estimates_t  observed;

    rate_disturbance_observer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // round(|a| * b / 2^sh) half away from zero, sign of a restored.
    // 128-bit product so the disturbance path (56 x 48 bits) stays exact.
    function automatic longint round_product(input longint a, input logic [63:0] b,
                                             input int sh);
        logic [127:0] mag;
        logic [127:0] prod;
        logic [63:0]  q;
        mag        = '0;
        mag[63:0]  = (a < 0) ? -a : a;
        prod       = mag * {64'd0, b};
        prod       = prod + (128'd1 << (sh - 1));
        prod       = prod >> sh;
        q          = prod[63:0];
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [VW-1:0] clamp_q16(input longint x);
        if (x > longint'($signed(Q_MAX)))
            return Q_MAX;
        if (x < longint'($signed(Q_MIN)))
            return Q_MIN;
        return x[VW-1:0];
    endfunction

    // Advance the mirrored observer by one item and return the new estimates.
    // Both integrators use the estimates held before the item.
    function automatic estimates_t observe(input logic cmd, input sample_t smp);
        estimates_t est;
        longint     g;
        longint     r;
        longint     d;
        longint     e;
        longint     ge;
        longint     s;
        longint     rinc;
        longint     dinc;
        for (int i = 0; i < AXES; i++)
        begin
            if (cmd)
            begin
                rate_model[i] = '0;
                dist_model[i] = '0;
            end
            else
            begin
                g    = longint'(gain_model[i]);
                r    = longint'(rate_model[i]);
                d    = longint'(dist_model[i]);
                e    = longint'($signed(smp.meas[i])) - r;
                ge   = g * e;
                s    = (longint'($signed(smp.drive[i])) + d) * 65536 + 2 * ge;
                rinc = round_product(s, 64'(smp.step_time), RATE_SH);
                dinc = round_product(ge, 64'(gain_model[i]) * 64'(smp.step_time), DIST_SH);
                rate_model[i] = clamp_q16(r + rinc);
                dist_model[i] = clamp_q16(d + dinc);
            end
            est.rate[i]    = rate_model[i];
            est.disturb[i] = dist_model[i];
        end
        return est;
    endfunction

    function automatic void compare_estimates(input estimates_t want, input estimates_t got);
        for (int i = 0; i < AXES; i++)
        begin
            if (got.rate[i] !== want.rate[i])
            begin
                $display("%0t: est_rate axis %0d expected %h actual %h",
                         $time, i, want.rate[i], got.rate[i]);
                mismatches++;
            end
            if (got.disturb[i] !== want.disturb[i])
            begin
                $display("%0t: est_dist axis %0d expected %h actual %h",
                         $time, i, want.disturb[i], got.disturb[i]);
                mismatches++;
            end
        end
    endfunction

    // Directed rows use the same value on all three axes.
    function automatic void add_item(input logic cmd, input logic [VW-1:0] meas,
                                     input logic [VW-1:0] drive, input logic [DTW-1:0] dt,
                                     input logic typed, input logic [VW-1:0] want_rate);
        stim_row_t row;
        row            = '0;
        row.kind       = ROW_ITEM;
        row.cmd        = cmd;
        row.smp.meas   = {3{meas}};
        row.smp.drive  = {3{drive}};
        row.smp.step_time = dt;
        row.typed      = typed;
        row.want.rate  = {3{want_rate}};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_gains(input logic [GW-1:0] gx, input logic [GW-1:0] gy,
                                      input logic [GW-1:0] gz);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_GAINS;
        row.gains = {gz, gy, gx};
        directed_rows.push_back(row);
    endfunction

    // Random Q16.16 value: mostly near a center, with corners and raw noise mixed in.
    function automatic logic [VW-1:0] pick_value(input logic [VW-1:0] center,
                                                 input int unsigned spread);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return '0;
                default: return Q_NEG1;
            endcase
        end
        if (roll < 20)
            return $urandom();
        return center + ($urandom_range(0, 2 * spread) - spread);
    endfunction

    function automatic logic [DTW-1:0] pick_step_time();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return DTW'($urandom_range(24'h00_2000, 24'h00_8000));
        if (roll < 80)
            return '0;
        if (roll < 85)
            return DT_MAX;
        return DTW'($urandom());
    endfunction

    function automatic logic [GW-1:0] pick_gain(input int mode);
        case (mode)
            0:       return GW'($urandom_range(24'h0A_0000, 24'h64_0000));  // 10..100 rad/s
            1:       return G_MAX;
            2:       return '0;
            3:       return GW'($urandom());
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return G_MAX;
                    default: return GW'($urandom_range(24'h0A_0000, 24'h64_0000));
                endcase
            end
        endcase
    endfunction

    // Present one item; valid stays up after acceptance so back-to-back items
    // never lower and raise it in the same step.
    task automatic send_item(input logic cmd, input sample_t smp, input logic typed,
                             input estimates_t want);
        row_expectations.push_back('{typed: typed, want: want});
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop sending and wait until every owed result is back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_estimates.size() != 0 || row_expectations.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [GW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Only called with the block idle. The unused index is hit every time and
    // must leave the gains alone.
    task automatic load_gains(input logic [GW-1:0] gx, input logic [GW-1:0] gy,
                              input logic [GW-1:0] gz);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_GAIN_Z, gz);
        write_reg(REG_UNUSED, GW'($urandom()));
        gain_settings++;
    endtask

    // Result sink: stalls about a third of the cycles unless in a steady stretch.
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Monitor: all handshakes are sampled on the rising edge. The output is
    // checked before the input of the same edge is predicted, so a result can
    // never be matched against its own item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed = m_axis_tdata;
                if (pending_estimates.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $time, observed);
                    mismatches++;
                end
                else
                begin
                    compare_estimates(pending_estimates.pop_front(), observed);
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                row_ref   = row_expectations.pop_front();
                predicted = observe(s_axis_tuser, s_axis_tdata);
                pending_estimates.push_back(row_ref.typed ? row_ref.want : predicted);
                if (s_axis_tuser)
                    clears_seen++;
                else
                    updates_seen++;
            end
            if (cfg_valid && cfg_ready && cfg_index <= REG_GAIN_Z)
                gain_model[cfg_index] = cfg_data;
        end
    end

    // Watchdog: far beyond the slowest legal run (~1300 items, each through the axis
    // program, plus stalls on both sides and the drains between phases).
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        stim_row_t          row;
        sample_t            smp;
        estimates_t         no_want;
        logic [2:0][VW-1:0] trend;
        logic               cmd;
        int                 mode;

        clk             = 1'b0;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tuser    = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        steady          = 1'b0;
        mismatches      = 0;
        results_checked = 0;
        updates_seen    = 0;
        clears_seen     = 0;
        gain_settings   = 0;
        no_want         = '0;
        trend           = '0;
        for (int i = 0; i < AXES; i++)
        begin
            gain_model[i] = '0;
            rate_model[i] = '0;
            dist_model[i] = '0;
        end

        // With zero gains the rate estimate just integrates the drive, so the
        // first rows have answers that can be worked out by hand.
        add_item(1'b0, Q_MAX, '0,    DT_MAX, 1'b1, '0);             // after reset, no drive
        add_item(1'b0, Q_MIN, '0,    DT_MAX, 1'b1, '0);
        add_item(1'b0, '0,    Q_MAX, '0,     1'b1, '0);             // zero step time
        add_item(1'b0, '0,    Q_MAX, DT_MAX, 1'b1, 32'h7FFF_FF7F);
        add_item(1'b0, '0,    Q_MAX, DT_MAX, 1'b1, Q_MAX);          // saturates high
        add_item(1'b1, Q_NEG1, Q_NEG1, DT_MAX, 1'b1, '0);           // clear ignores sample
        add_item(1'b0, '0,    Q_MIN, DT_MAX, 1'b1, 32'h8000_0080);
        add_item(1'b0, '0,    Q_MIN, DT_MAX, 1'b1, Q_MIN);          // saturates low
        // estimates sit at the negative rail, so a full-scale measurement
        // gives the widest possible error
        add_gains(G_MAX, G_ONE, 24'h00_0001);
        add_item(1'b0, Q_MAX,  '0,     24'h00_0400, 1'b0, '0);
        add_item(1'b0, Q_MAX,  Q_MAX,  DT_MAX,      1'b0, '0);
        add_item(1'b0, Q_MIN,  Q_MIN,  DT_MAX,      1'b0, '0);
        add_item(1'b0, '0,     Q_MIN,  24'h00_0001, 1'b0, '0);
        add_item(1'b0, Q_NEG1, Q_NEG1, 24'h80_0000, 1'b0, '0);
        add_item(1'b0, Q_MAX,  '0,     '0,          1'b0, '0);
        add_item(1'b1, '0,     '0,     '0,          1'b1, '0);
        add_item(1'b0, Q_ONE,  '0,     24'h01_0000, 1'b0, '0);      // tracking a step
        add_item(1'b0, Q_ONE,  '0,     24'h01_0000, 1'b0, '0);
        add_item(1'b0, Q_ONE,  '0,     24'h01_0000, 1'b0, '0);
        add_gains(G_MAX, G_MAX, G_MAX);
        add_item(1'b0, Q_MAX,  Q_MAX,  DT_MAX,      1'b0, '0);
        add_item(1'b0, Q_MIN,  Q_MIN,  DT_MAX,      1'b0, '0);
        add_item(1'b0, Q_MAX,  Q_MIN,  DT_MAX,      1'b0, '0);
        add_item(1'b1, Q_MAX,  Q_MAX,  DT_MAX,      1'b1, '0);
        add_gains('0, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.kind == ROW_GAINS)
            begin
                drain_results();
                load_gains(row.gains[0], row.gains[1], row.gains[2]);
            end
            else
                send_item(row.cmd, row.smp, row.typed, row.want);
        end
        drain_results();

        // Random phases: each with its own gains. Most samples follow a slowly
        // drifting true rate with small drive, the way a control loop feeds the
        // observer; corners, raw noise and clears are mixed in.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            mode = ph % 5;
            load_gains(pick_gain(mode), pick_gain(mode), pick_gain(mode));
            steady = (ph == 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold off mid-phase until the pipeline is empty
                if (n == ITEMS_PER_PHASE / 2 && ph % 3 == 1)
                    drain_results();
                for (int i = 0; i < AXES; i++)
                begin
                    trend[i]     = trend[i] + ($urandom_range(0, 8192) - 4096);
                    smp.meas[i]  = pick_value(trend[i], 1024);
                    smp.drive[i] = pick_value('0, 32'h0004_0000);
                end
                smp.step_time = pick_step_time();
                cmd = ($urandom_range(0, 99) < 5);
                send_item(cmd, smp, 1'b0, no_want);
            end
            drain_results();
            steady = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_estimates.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_estimates.size());
            mismatches++;
        end

        $display("Run covered %0d updates and %0d clears under %0d gain settings,",
                 updates_seen, clears_seen, gain_settings);
        $display("with %0d results compared and %0d field mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
